/* hw/rtl/bc1_block_decoder_macros.svh */
// ----------------------------------------------------------------------------
// BC1 block decoder assertion macros
// Shared property wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef BC1_BLOCK_DECODER_MACROS_SVH
`define BC1_BLOCK_DECODER_MACROS_SVH

// same-cycle implication
`define BC1_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bc1 assertion failed");

// next-cycle implication
`define BC1_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bc1 assertion failed");

// delayed implication
`define BC1_ASSERT_TWO(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> ##2 (cons)) \
        else $error("bc1 assertion failed");

`endif

/* hw/rtl/bc1_pkg.sv */
// ----------------------------------------------------------------------------
// BC1 decoder package
// Row numbering constants and endpoint/palette helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bc1_pkg;

    typedef logic [1:0]  row_t;
    typedef logic [31:0] texel_t;
    typedef logic [7:0]  chan_t;

    localparam row_t FIRST_ROW = 2'd0;
    localparam row_t LAST_ROW  = 2'd3;

    localparam chan_t       ALPHA_OPAQUE = 8'hFF;
    localparam texel_t      TRANSPARENT  = 32'h0000_0000;
    localparam logic [10:0] RECIP_THREE  = 11'd683;

    function automatic chan_t expand5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic chan_t expand6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    // x / 3 for x < 768 as (x * 683) >> 11
    function automatic chan_t div3(input logic [9:0] x);
        logic [20:0] p;
        p = {11'd0, x} * {10'd0, RECIP_THREE};
        return p[18:11];
    endfunction

    function automatic texel_t pick(input texel_t p0, input texel_t p1,
                                    input texel_t p2, input texel_t p3,
                                    input logic [1:0] code);
        texel_t r;
        case (code)
            2'd0:    r = p0;
            2'd1:    r = p1;
            2'd2:    r = p2;
            default: r = p3;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/bc1_block_decoder.sv */
// ----------------------------------------------------------------------------
// BC1 block decoder
// Decodes one 64-bit BC1 block into four rows of four RGBA8888 texels.
// ----------------------------------------------------------------------------
// An accepted block is held in the block register, then each row goes to the
// output register. Blocks are taken as fast as their four row beats drain.
// Palette is built in the input cycle; the next block is taken as the last
// row of the current one moves into the output register.
// Reset: synchronous, active low; clears the block and output valid flags.
`timescale 1ns / 1ps
`default_nettype none

module bc1_block_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_endpoint_a,
    input  wire logic [15:0] s_endpoint_b,
    input  wire logic [31:0] s_index_bits,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_row_number,
    output logic [31:0]      m_texel_zero,
    output logic [31:0]      m_texel_one,
    output logic [31:0]      m_texel_two,
    output logic [31:0]      m_texel_three,
    output logic             m_last_row
);

    logic [7:0] a_r, a_g, a_b, b_r, b_g, b_b;
    logic       four_color;
    bc1_pkg::texel_t pal0_next, pal1_next, pal2_next, pal3_next;
    bc1_pkg::texel_t pal0_reg, pal1_reg, pal2_reg, pal3_reg;
    logic [31:0]     idx_reg;
    logic            blk_valid_reg;
    bc1_pkg::row_t   row_reg;
    logic            out_load;
    logic            s_fire;
    logic [7:0]      row_bits;

    logic            out_valid_reg;
    bc1_pkg::row_t   out_row_reg;
    bc1_pkg::texel_t out_t0_reg, out_t1_reg, out_t2_reg, out_t3_reg;
    logic            out_last_reg;

    always_comb begin
        a_r = bc1_pkg::expand5(s_endpoint_a[15:11]);
        a_g = bc1_pkg::expand6(s_endpoint_a[10:5]);
        a_b = bc1_pkg::expand5(s_endpoint_a[4:0]);
        b_r = bc1_pkg::expand5(s_endpoint_b[15:11]);
        b_g = bc1_pkg::expand6(s_endpoint_b[10:5]);
        b_b = bc1_pkg::expand5(s_endpoint_b[4:0]);
        four_color = s_endpoint_a > s_endpoint_b;
        pal0_next = {a_r, a_g, a_b, bc1_pkg::ALPHA_OPAQUE};
        pal1_next = {b_r, b_g, b_b, bc1_pkg::ALPHA_OPAQUE};
        if (four_color) begin
            pal2_next = {
                bc1_pkg::div3({1'b0, a_r, 1'b0} + {2'b0, b_r} + 10'd1),
                bc1_pkg::div3({1'b0, a_g, 1'b0} + {2'b0, b_g} + 10'd1),
                bc1_pkg::div3({1'b0, a_b, 1'b0} + {2'b0, b_b} + 10'd1),
                bc1_pkg::ALPHA_OPAQUE};
            pal3_next = {
                bc1_pkg::div3({2'b0, a_r} + {1'b0, b_r, 1'b0} + 10'd1),
                bc1_pkg::div3({2'b0, a_g} + {1'b0, b_g, 1'b0} + 10'd1),
                bc1_pkg::div3({2'b0, a_b} + {1'b0, b_b, 1'b0} + 10'd1),
                bc1_pkg::ALPHA_OPAQUE};
        end else begin
            pal2_next[31:24] = 8'(({1'b0, a_r} + {1'b0, b_r} + 9'd1) >> 1);
            pal2_next[23:16] = 8'(({1'b0, a_g} + {1'b0, b_g} + 9'd1) >> 1);
            pal2_next[15:8]  = 8'(({1'b0, a_b} + {1'b0, b_b} + 9'd1) >> 1);
            pal2_next[7:0]   = bc1_pkg::ALPHA_OPAQUE;
            pal3_next = bc1_pkg::TRANSPARENT;
        end
    end

    assign out_load = !out_valid_reg || m_ready;
    assign s_ready  = !blk_valid_reg || (out_load && row_reg == bc1_pkg::LAST_ROW);
    assign s_fire   = s_valid && s_ready;
    assign row_bits = idx_reg[{row_reg, 3'b000} +: 8];

    // block register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_valid_reg <= 1'b0;
            row_reg       <= bc1_pkg::FIRST_ROW;
        end else begin
            if (s_fire) begin
                blk_valid_reg <= 1'b1;
                row_reg       <= bc1_pkg::FIRST_ROW;
            end else if (blk_valid_reg && out_load) begin
                row_reg <= row_reg + 2'd1;
                if (row_reg == bc1_pkg::LAST_ROW) begin
                    blk_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pal0_reg <= pal0_next;
            pal1_reg <= pal1_next;
            pal2_reg <= pal2_next;
            pal3_reg <= pal3_next;
            idx_reg  <= s_index_bits;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= blk_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && blk_valid_reg) begin
            out_row_reg  <= row_reg;
            out_last_reg <= row_reg == bc1_pkg::LAST_ROW;
            out_t0_reg   <= bc1_pkg::pick(pal0_reg, pal1_reg, pal2_reg, pal3_reg,
                                          row_bits[1:0]);
            out_t1_reg   <= bc1_pkg::pick(pal0_reg, pal1_reg, pal2_reg, pal3_reg,
                                          row_bits[3:2]);
            out_t2_reg   <= bc1_pkg::pick(pal0_reg, pal1_reg, pal2_reg, pal3_reg,
                                          row_bits[5:4]);
            out_t3_reg   <= bc1_pkg::pick(pal0_reg, pal1_reg, pal2_reg, pal3_reg,
                                          row_bits[7:6]);
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_row_number  = out_row_reg;
    assign m_texel_zero  = out_t0_reg;
    assign m_texel_one   = out_t1_reg;
    assign m_texel_two   = out_t2_reg;
    assign m_texel_three = out_t3_reg;
    assign m_last_row    = out_last_reg;

endmodule

`default_nettype wire

/* hw/rtl/bc1_checker.sv */
// ----------------------------------------------------------------------------
// BC1 decoder checker
// Port-level checks on row ordering, last-row marking, stalls and latency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bc1_block_decoder_macros.svh"

module bc1_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_row_number,
    input wire logic [31:0] m_texel_zero,
    input wire logic        m_last_row
);

    bc1_pkg::row_t exp_row_reg;

    // track expected row of the next result beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_row_reg <= bc1_pkg::FIRST_ROW;
        end else if (m_valid && m_ready) begin
            exp_row_reg <= exp_row_reg + 2'd1;
        end
    end

    `BC1_ASSERT_NOW(a_row_order, aclk, aresetn, m_valid, m_row_number == exp_row_reg)
    `BC1_ASSERT_NOW(a_last_mark, aclk, aresetn, m_valid,
        m_last_row == (m_row_number == bc1_pkg::LAST_ROW))
    `BC1_ASSERT_TWO(a_latency, aclk, aresetn, s_valid && s_ready, m_valid)
    `BC1_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_row_number) && $stable(m_texel_zero))

endmodule

bind bc1_block_decoder bc1_checker u_bc1_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_row_number (m_row_number),
    .m_texel_zero (m_texel_zero),
    .m_last_row   (m_last_row)
);

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// BC1 block decoder testbench
// Drives BC1 blocks through the valid/ready input channel and checks every
// row beat against an in-bench palette decoder or a fill color. Directed
// table blocks come first, then random ones under several idle/stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        bc1_pkg::row_t          row;
        bc1_pkg::texel_t [3:0]  tex;
        logic                   last;
    } row_beat_t;

    typedef struct packed {
        logic [15:0]     ca;
        logic [15:0]     cb;
        logic [31:0]     idx;
        logic            fixed;
        bc1_pkg::texel_t fill;
    } block_case_t;

    localparam int NUM_DIRECTED = 21;

    // fixed rows: every texel of the block decodes to the same color
    localparam block_case_t DIRECTED [0:NUM_DIRECTED-1] = '{
        '{16'hFFFF, 16'h0000, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
        '{16'hFFFF, 16'h0000, 32'h5555_5555, 1'b1, 32'h0000_00FF},
        '{16'hFFFF, 16'h0000, 32'hAAAA_AAAA, 1'b1, 32'hAAAA_AAFF},
        '{16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 1'b1, 32'h5555_55FF},
        '{16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{16'h0000, 16'hFFFF, 32'hAAAA_AAAA, 1'b1, 32'h8080_80FF},
        '{16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 32'h0000_00FF},
        '{16'hFFFF, 16'hFFFF, 32'hAAAA_AAAA, 1'b1, 32'hFFFF_FFFF},
        '{16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{16'hF800, 16'h07E0, 32'hE4E4_E4E4, 1'b0, 32'h0},
        '{16'h07E0, 16'hF800, 32'hE4E4_E4E4, 1'b0, 32'h0},
        '{16'h001F, 16'h0000, 32'h1B1B_1B1B, 1'b0, 32'h0},
        '{16'h0001, 16'h0000, 32'hE4E4_E4E4, 1'b0, 32'h0},
        '{16'h8000, 16'h8001, 32'hE4E4_E4E4, 1'b0, 32'h0},
        '{16'h8410, 16'h8410, 32'hE4E4_E4E4, 1'b0, 32'h0},
        '{16'h7BEF, 16'h8410, 32'h1234_5678, 1'b0, 32'h0},
        '{16'h1234, 16'hABCD, 32'hFEDC_BA98, 1'b0, 32'h0},
        '{16'hABCD, 16'h1234, 32'h0F0F_0F0F, 1'b0, 32'h0},
        '{16'hFFFF, 16'hFFFE, 32'hE4E4_E4E4, 1'b0, 32'h0},
        '{16'h0000, 16'h0001, 32'hE4E4_E4E4, 1'b0, 32'h0}
    };

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [15:0] s_endpoint_a = '0;
    logic [15:0] s_endpoint_b = '0;
    logic [31:0] s_index_bits = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [1:0]  m_row_number;
    logic [31:0] m_texel_zero;
    logic [31:0] m_texel_one;
    logic [31:0] m_texel_two;
    logic [31:0] m_texel_three;
    logic        m_last_row;

    row_beat_t rows_due [$];
    int        mismatch_count = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;

    bc1_block_decoder u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_endpoint_a  (s_endpoint_a),
        .s_endpoint_b  (s_endpoint_b),
        .s_index_bits  (s_index_bits),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_row_number  (m_row_number),
        .m_texel_zero  (m_texel_zero),
        .m_texel_one   (m_texel_one),
        .m_texel_two   (m_texel_two),
        .m_texel_three (m_texel_three),
        .m_last_row    (m_last_row)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int widen(input int v, input int bits);
        return (bits == 5) ? ((v << 3) | (v >> 2)) : ((v << 2) | (v >> 4));
    endfunction

    function automatic bc1_pkg::texel_t pack_texel(input int r, input int g, input int b);
        return {r[7:0], g[7:0], b[7:0], bc1_pkg::ALPHA_OPAQUE};
    endfunction

    task automatic queue_rows(input bc1_pkg::texel_t pal [4], input logic [31:0] idx);
        row_beat_t beat;
        for (int r = 0; r < 4; r++) begin
            beat.row = bc1_pkg::row_t'(r);
            for (int t = 0; t < 4; t++)
                beat.tex[t] = pal[idx[8 * r + 2 * t +: 2]];
            beat.last = (bc1_pkg::row_t'(r) == bc1_pkg::LAST_ROW);
            rows_due.push_back(beat);
        end
    endtask

    task automatic decode_block(input logic [15:0] ca, input logic [15:0] cb,
                                input logic [31:0] idx);
        int              e0 [3];
        int              e1 [3];
        int              m2 [3];
        int              m3 [3];
        bc1_pkg::texel_t pal [4];
        e0[0] = widen(ca[15:11], 5);
        e0[1] = widen(ca[10:5], 6);
        e0[2] = widen(ca[4:0], 5);
        e1[0] = widen(cb[15:11], 5);
        e1[1] = widen(cb[10:5], 6);
        e1[2] = widen(cb[4:0], 5);
        for (int k = 0; k < 3; k++) begin
            if (ca > cb) begin
                m2[k] = (2 * e0[k] + e1[k] + 1) / 3;
                m3[k] = (e0[k] + 2 * e1[k] + 1) / 3;
            end else begin
                m2[k] = (e0[k] + e1[k] + 1) / 2;
                m3[k] = 0;
            end
        end
        pal[0] = pack_texel(e0[0], e0[1], e0[2]);
        pal[1] = pack_texel(e1[0], e1[1], e1[2]);
        pal[2] = pack_texel(m2[0], m2[1], m2[2]);
        pal[3] = (ca > cb) ? pack_texel(m3[0], m3[1], m3[2]) : bc1_pkg::TRANSPARENT;
        queue_rows(pal, idx);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 100)
            $display("%0t: %s mismatch, got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : check_rows
        row_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (rows_due.size() == 0) begin
                report_mismatch("unexpected row beat", {30'd0, m_row_number}, '0);
            end else begin
                want = rows_due.pop_front();
                if (m_row_number !== want.row)
                    report_mismatch("row_number", {30'd0, m_row_number}, {30'd0, want.row});
                if (m_texel_zero !== want.tex[0])
                    report_mismatch("texel_zero", m_texel_zero, want.tex[0]);
                if (m_texel_one !== want.tex[1])
                    report_mismatch("texel_one", m_texel_one, want.tex[1]);
                if (m_texel_two !== want.tex[2])
                    report_mismatch("texel_two", m_texel_two, want.tex[2]);
                if (m_texel_three !== want.tex[3])
                    report_mismatch("texel_three", m_texel_three, want.tex[3]);
                if (m_last_row !== want.last)
                    report_mismatch("last_row", {31'd0, m_last_row}, {31'd0, want.last});
            end
        end
    end

    task automatic send_block(input block_case_t blk);
        bc1_pkg::texel_t pal [4];
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_endpoint_a <= blk.ca;
        s_endpoint_b <= blk.cb;
        s_index_bits <= blk.idx;
        do @(posedge aclk); while (!s_ready);
        if (blk.fixed) begin
            for (int k = 0; k < 4; k++)
                pal[k] = blk.fill;
            queue_rows(pal, blk.idx);
        end else begin
            decode_block(blk.ca, blk.cb, blk.idx);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (rows_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_random(input int count);
        block_case_t blk;
        logic [15:0] swap;
        for (int n = 0; n < count; n++) begin
            blk.ca    = 16'($urandom);
            blk.cb    = 16'($urandom);
            blk.idx   = $urandom;
            blk.fixed = 1'b0;
            blk.fill  = '0;
            case ($urandom_range(9))
                0: blk.cb = blk.ca;
                1, 2, 3, 4: begin
                    if (blk.ca < blk.cb) begin
                        swap   = blk.ca;
                        blk.ca = blk.cb;
                        blk.cb = swap;
                    end
                end
                5, 6, 7, 8: begin
                    if (blk.ca > blk.cb) begin
                        swap   = blk.ca;
                        blk.ca = blk.cb;
                        blk.cb = swap;
                    end
                end
                default: blk.cb = blk.ca ^ (16'd1 << $urandom_range(15));
            endcase
            send_block(blk);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_block(DIRECTED[i]);

        send_random(50);
        wait_drained();

        send_idle_pct  = 59;
        recv_stall_pct = 0;
        send_random(50);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 59;
        send_random(50);
        wait_drained();

        send_idle_pct  = 17;
        recv_stall_pct = 17;
        send_random(50);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && rows_due.size() == 0)
            $display("PASS bc1_block_decoder");
        else
            $display("FAIL bc1_block_decoder");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL bc1_block_decoder");
        $finish;
    end

endmodule
